// ===== hw/rtl/drd_pkg.sv =====
// ----------------------------------------------------------------------------
// drd_pkg
// Shared types, widths and helpers of the detection row decoder.
// ----------------------------------------------------------------------------
package drd_pkg;

    localparam int VALUE_W     = 32;
    localparam int ROW_IDX_W   = 14;
    localparam int CLASS_W     = 7;
    localparam int PIX_W       = 16;
    localparam int POS_W       = 8;
    localparam int CC_W        = 8;
    localparam int RC_W        = 15;
    localparam int THR_W       = 17;
    localparam int SCALE_W     = 24;
    // 2*a - b of two Q16.16 values, Q.17
    localparam int NUM_W       = VALUE_W + 2;
    localparam int PROD_W      = NUM_W + SCALE_W + 1;
    localparam int FRAC_SHIFT  = 33;
    localparam int QUOT_W      = PROD_W - FRAC_SHIFT;
    localparam int NUM_TERMS   = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 120;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE         = 3'd4;

    localparam logic [CC_W-1:0]    RST_CLASS_COUNT     = 8'd80;
    localparam logic [RC_W-1:0]    RST_ROW_COUNT       = 15'd8400;
    localparam logic [THR_W-1:0]   RST_SCORE_THRESHOLD = 17'd16384;
    localparam logic [SCALE_W-1:0] RST_X_SCALE         = 24'd65536;
    localparam logic [SCALE_W-1:0] RST_Y_SCALE         = 24'd65536;

    typedef struct packed {
        logic [CC_W-1:0]    class_count;
        logic [RC_W-1:0]    row_count;
        logic [THR_W-1:0]   score_threshold;
        logic [SCALE_W-1:0] x_scale;
        logic [SCALE_W-1:0] y_scale;
    } cfg_t;

    // one detection waiting for scaling; num holds 2x-w, 2y-h, 2w, 2h
    typedef struct packed {
        logic [ROW_IDX_W-1:0]                row_index;
        logic [CLASS_W-1:0]                  class_index;
        logic [VALUE_W-1:0]                  confidence;
        logic [NUM_TERMS-1:0][NUM_W-1:0]     num;
    } job_t;

    // packed so that row_index sits in the lowest bits
    typedef struct packed {
        logic [PIX_W-1:0]     box_height;
        logic [PIX_W-1:0]     box_width;
        logic [PIX_W-1:0]     box_top;
        logic [PIX_W-1:0]     box_left;
        logic [VALUE_W-1:0]   confidence;
        logic [CLASS_W-1:0]   class_index;
        logic [ROW_IDX_W-1:0] row_index;
    } result_t;

    // product / 2^33, truncated toward zero, saturated to 16 bits
    function automatic logic [PIX_W-1:0] sat_px(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] bias;
        logic signed [PROD_W-1:0] sum;
        logic        [QUOT_W-1:0] q;
        bias = '0;
        if (p[PROD_W-1]) begin
            bias[FRAC_SHIFT-1:0] = '1;
        end
        sum = p + bias;
        q   = sum[PROD_W-1:FRAC_SHIFT];
        if ((&q[QUOT_W-1:PIX_W-1]) || !(|q[QUOT_W-1:PIX_W-1])) begin
            sat_px = q[PIX_W-1:0];
        end else if (q[QUOT_W-1]) begin
            sat_px = {1'b1, {(PIX_W-1){1'b0}}};
        end else begin
            sat_px = {1'b0, {(PIX_W-1){1'b1}}};
        end
    endfunction

endpackage

// ===== hw/rtl/detection_row_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// detection_row_decoder_unit
// Decodes detector output rows into scaled, thresholded detections.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Ports                         Beat carries
//  --------  ---  ----------------------------  ------------------------------
//  s_        in   s_tvalid s_tready s_tdata     one Q16.16 tensor element
//  m_        out  m_tvalid m_tready m_tdata     one detection
//  cfg_      in   cfg_valid cfg_ready cfg_index register write
//                 cfg_data
//
//  One input beat per clock while s_tready is high. A row of 4 + class_count
//  beats gives at most one detection; m_tvalid rises once its job has passed
//  the job queue, the states MUL0 to MUL3 and LAST, and the output register.
//  The scaling engine shares one multiplier over the four box terms, steps
//  through those states per detection and keeps up with the shortest row
//  (5 beats). A two-job queue decouples the row tracker from the engine;
//  s_tready drops only while it is full, i.e. when m_tready is held low.
//  Reset is synchronous on aresetn low: counters, handshake state and the
//  configuration registers return to their defaults. cfg_ready is always high.
//
module detection_row_decoder_unit #(
    parameter int MAX_CLASSES = 128,
    parameter int MAX_ROWS    = 16384
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] value
    input  logic [drd_pkg::S_TDATA_W-1:0]     s_tdata,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [13:0] row_index, [20:14] class_index, [52:21] confidence,
    // [68:53] box_left, [84:69] box_top, [100:85] box_width,
    // [116:101] box_height, [119:117] zero
    output logic [drd_pkg::M_TDATA_W-1:0]     m_tdata,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [drd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [drd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import drd_pkg::*;

    cfg_t    cfg_reg;
    logic    s_accept;
    logic    push, pop, q_full, q_valid;
    job_t    push_job, head_job;
    result_t res;

    // --- configuration registers --------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.class_count     <= RST_CLASS_COUNT;
            cfg_reg.row_count       <= RST_ROW_COUNT;
            cfg_reg.score_threshold <= RST_SCORE_THRESHOLD;
            cfg_reg.x_scale         <= RST_X_SCALE;
            cfg_reg.y_scale         <= RST_Y_SCALE;
        end else if (cfg_valid) begin
            // drop writes to indexes outside the register list
            unique case (cfg_index)
                REG_CLASS_COUNT:     cfg_reg.class_count     <= cfg_data[CC_W-1:0];
                REG_ROW_COUNT:       cfg_reg.row_count       <= cfg_data[RC_W-1:0];
                REG_SCORE_THRESHOLD: cfg_reg.score_threshold <= cfg_data[THR_W-1:0];
                REG_X_SCALE:         cfg_reg.x_scale         <= cfg_data[SCALE_W-1:0];
                REG_Y_SCALE:         cfg_reg.y_scale         <= cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // --- front: accept beats while the job queue has room --------------------
    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    drd_front #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_accept (s_accept),
        .in_value  (s_tdata[VALUE_W-1:0]),
        .push      (push),
        .job       (push_job)
    );

    // --- job queue ----------------------------------------------------------
    drd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (head_job)
    );

    // --- back: scale the box and hold the result for m_ ---------------------
    drd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .x_scale   (cfg_reg.x_scale),
        .y_scale   (cfg_reg.y_scale),
        .job_valid (q_valid),
        .job       (head_job),
        .pop       (pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // pad the packed detection with zeros up to whole bytes
    assign m_tdata = M_TDATA_W'(res);

endmodule

// ===== hw/rtl/drd_front.sv =====
// ----------------------------------------------------------------------------
// drd_front
// Row tracker: stores the box values, keeps the arg-max over the scores and
// issues a job at the end of a row whose best score beats the threshold.
// ----------------------------------------------------------------------------
module drd_front #(
    parameter int MAX_CLASSES = 128,
    parameter int MAX_ROWS    = 16384
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  drd_pkg::cfg_t                   cfg,
    input  logic                            in_accept,
    input  logic [drd_pkg::VALUE_W-1:0]     in_value,
    output logic                            push,
    output drd_pkg::job_t                   job
);
    import drd_pkg::*;

    localparam int LAST_W = ($clog2(MAX_CLASSES + 4) > POS_W) ? $clog2(MAX_CLASSES + 4) : POS_W;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RLIM_W = ($clog2(MAX_ROWS + 1) > RC_W) ? $clog2(MAX_ROWS + 1) : RC_W;

    localparam logic [POS_W-1:0] POS_X           = 8'd0;
    localparam logic [POS_W-1:0] POS_Y           = 8'd1;
    localparam logic [POS_W-1:0] POS_W_BOX       = 8'd2;
    localparam logic [POS_W-1:0] POS_H_BOX       = 8'd3;
    localparam logic [POS_W-1:0] POS_FIRST_SCORE = 8'd4;

    logic [POS_W-1:0]          pos_reg;
    logic [ROW_W-1:0]          row_reg;
    logic signed [VALUE_W-1:0] cx_reg, cy_reg, w_reg, h_reg;
    logic signed [VALUE_W-1:0] best_reg, best_next;
    logic [CLASS_W-1:0]        cls_reg, cls_next;

    logic signed [VALUE_W-1:0] v;
    logic [LAST_W-1:0]         cc_ext, classes, last;
    logic [RLIM_W-1:0]         rc_ext, row_lim, row_inc;
    logic                      row_end, pass;

    assign v = $signed(in_value);

    // clamp the class and row counts into range
    always_comb begin
        cc_ext = LAST_W'(cfg.class_count);
        if (cfg.class_count == '0) begin
            classes = LAST_W'(1);
        end else if (cc_ext > LAST_W'(MAX_CLASSES)) begin
            classes = LAST_W'(MAX_CLASSES);
        end else begin
            classes = cc_ext;
        end
        last = classes + LAST_W'(3);

        rc_ext = RLIM_W'(cfg.row_count);
        if (cfg.row_count == '0) begin
            row_lim = RLIM_W'(1);
        end else if (rc_ext > RLIM_W'(MAX_ROWS)) begin
            row_lim = RLIM_W'(MAX_ROWS);
        end else begin
            row_lim = rc_ext;
        end
        row_inc = RLIM_W'(row_reg) + RLIM_W'(1);
    end

    always_comb begin
        best_next = best_reg;
        cls_next  = cls_reg;
        if (pos_reg == POS_FIRST_SCORE) begin
            best_next = v;
            cls_next  = '0;
        end else if (pos_reg > POS_FIRST_SCORE && v > best_reg) begin
            best_next = v;
            cls_next  = CLASS_W'(pos_reg - POS_FIRST_SCORE);
        end
        row_end = LAST_W'(pos_reg) >= last;
        pass    = $signed({best_next[VALUE_W-1], best_next}) >
                  $signed({{(VALUE_W + 1 - THR_W){1'b0}}, cfg.score_threshold});
    end

    assign push = in_accept && row_end && pass;

    always_comb begin
        job.row_index   = ROW_IDX_W'(row_reg);
        job.class_index = cls_next;
        job.confidence  = best_next;
        job.num[0] = $signed({cx_reg[VALUE_W-1], cx_reg, 1'b0})
                   - $signed({{2{w_reg[VALUE_W-1]}}, w_reg});
        job.num[1] = $signed({cy_reg[VALUE_W-1], cy_reg, 1'b0})
                   - $signed({{2{h_reg[VALUE_W-1]}}, h_reg});
        job.num[2] = {w_reg[VALUE_W-1], w_reg, 1'b0};
        job.num[3] = {h_reg[VALUE_W-1], h_reg, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            row_reg <= '0;
        end else if (in_accept) begin
            if (row_end) begin
                pos_reg <= '0;
                row_reg <= (row_inc >= row_lim) ? '0 : ROW_W'(row_inc);
            end else begin
                pos_reg <= pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            if (pos_reg == POS_X) begin
                cx_reg <= v;
            end
            if (pos_reg == POS_Y) begin
                cy_reg <= v;
            end
            if (pos_reg == POS_W_BOX) begin
                w_reg <= v;
            end
            if (pos_reg == POS_H_BOX) begin
                h_reg <= v;
            end
            best_reg <= best_next;
            cls_reg  <= cls_next;
        end
    end

endmodule

// ===== hw/rtl/drd_queue.sv =====
// ----------------------------------------------------------------------------
// drd_queue
// Short job queue between the row tracker and the scaling engine.
// ----------------------------------------------------------------------------
module drd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  drd_pkg::job_t   push_job,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output drd_pkg::job_t   head
);
    import drd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = slots_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hw/rtl/drd_back.sv =====
// ----------------------------------------------------------------------------
// drd_back
// Scaling engine: one shared multiplier forms the four pixel values of a
// job in states MUL0 to MUL3, then the result moves to the output register.
// ----------------------------------------------------------------------------
module drd_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [drd_pkg::SCALE_W-1:0]    x_scale,
    input  logic [drd_pkg::SCALE_W-1:0]    y_scale,
    input  logic                           job_valid,
    input  drd_pkg::job_t                  job,
    output logic                           pop,
    output logic                           res_valid,
    input  logic                           res_ready,
    output drd_pkg::result_t               res
);
    import drd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL0 = 3'd1;
    localparam logic [2:0] ST_MUL1 = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_MUL3 = 3'd4;
    localparam logic [2:0] ST_LAST = 3'd5;

    logic [2:0]               state_reg, state_next;
    job_t                     job_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [PIX_W-1:0]         pix_reg [3];
    logic                     out_valid_reg;
    result_t                  out_reg;

    logic                     issue_en, sat_en, last_go, out_free;
    logic [1:0]               term;
    logic [NUM_W-1:0]         num_sel;
    logic [SCALE_W-1:0]       scale_sel;
    logic [PIX_W-1:0]         px;

    assign out_free = !out_valid_reg || res_ready;
    assign last_go  = (state_reg == ST_LAST) && out_free;
    assign pop      = job_valid && (state_reg == ST_IDLE || last_go);
    assign px       = sat_px(prod_reg);

    always_comb begin
        issue_en   = 1'b0;
        sat_en     = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                state_next = pop ? ST_MUL0 : ST_IDLE;
            end
            ST_MUL0: begin
                issue_en   = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1, ST_MUL2: begin
                issue_en   = 1'b1;
                sat_en     = 1'b1;
                state_next = state_reg + 3'd1;
            end
            ST_MUL3: begin
                issue_en   = 1'b1;
                sat_en     = 1'b1;
                state_next = ST_LAST;
            end
            ST_LAST: begin
                // hold until the output register frees up
                if (last_go) begin
                    state_next = pop ? ST_MUL0 : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // left and width use x_scale, top and height y_scale
    always_comb begin
        term      = 2'(state_reg - ST_MUL0);
        num_sel   = job_reg.num[term];
        scale_sel = term[0] ? y_scale : x_scale;
        prod_next = $signed(num_sel) * $signed({1'b0, scale_sel});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (last_go) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= job;
        end
        if (issue_en) begin
            prod_reg <= prod_next;
        end
        if (sat_en) begin
            pix_reg[2'(state_reg - ST_MUL1)] <= px;
        end
        if (last_go) begin
            out_reg.row_index   <= job_reg.row_index;
            out_reg.class_index <= job_reg.class_index;
            out_reg.confidence  <= job_reg.confidence;
            out_reg.box_left    <= pix_reg[0];
            out_reg.box_top     <= pix_reg[1];
            out_reg.box_width   <= pix_reg[2];
            out_reg.box_height  <= px;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule
